// ===== hdl/kas_pkg.sv =====
// Shared types, constants and helpers for the ball kick approach steering block.
package kas_pkg;

  localparam int CoordW = 16;
  localparam int DiffW  = 18;
  localparam int SqW    = 36;
  localparam int RemW   = 22;
  localparam int DvsW   = 20;
  localparam int CntW   = 6;
  localparam int SpdW   = 15;

  localparam logic [SpdW-1:0] SpdSupport   = 15'd4915;
  localparam logic [SpdW-1:0] SpdFast      = 15'd6144;
  localparam logic [SpdW-1:0] ApproachBack = 15'd300;
  localparam logic signed [DiffW-1:0] SupportBack = 18'sd800;
  localparam logic signed [DiffW-1:0] SupportMinX = -18'sd3500;
  localparam logic [SqW-1:0] SupportNearSq  = 36'd25600;
  localparam logic [SqW-1:0] ChaseSq        = 36'd360000;
  localparam logic [SqW-1:0] ApproachNearSq = 36'd900;

  typedef enum logic [2:0] {
    CFG_GOAL_X, CFG_GOAL_Y, CFG_KICK_RANGE,
    CFG_HOLD_MS, CFG_KICK_STRENGTH, CFG_FAR_SPEED
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0]               bot_id;
    logic                     robot_valid;
    logic                     ball_valid;
    logic signed [CoordW-1:0] robot_x;
    logic signed [CoordW-1:0] robot_y;
    logic signed [CoordW-1:0] ball_x;
    logic signed [CoordW-1:0] ball_y;
    logic [31:0]              now_ms;
  } tick_t;

  typedef struct packed {
    logic [3:0]               cmd_bot_id;
    logic signed [CoordW-1:0] vel_x;
    logic signed [CoordW-1:0] vel_y;
    logic                     kick;
    logic [7:0]               kick_power_out;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_KSQ, S_SQX, S_SQY, S_SQA, S_CHECK, S_ROOT, S_ROOTW,
    S_MULX, S_DIVX, S_DIVXW, S_MULY, S_DIVY, S_DIVYW, S_NEXT, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_SUPPORT, PH_CLASS, PH_KICK, PH_CHASE, PH_GOAL, PH_APPROACH
  } phase_t;

  // quotient magnitude to signed 16 bit, saturating
  function automatic logic signed [CoordW-1:0] sat_q(input logic [SqW-1:0] q,
                                                     input logic neg);
    logic signed [CoordW-1:0] r;
    if (neg) begin
      if (q > 36'd32768) r = -16'sd32768;
      else r = -$signed(q[CoordW-1:0]);
    end else begin
      if (q > 36'd32767) r = 16'sd32767;
      else r = $signed(q[CoordW-1:0]);
    end
    return r;
  endfunction

endpackage

// ===== hdl/kas_iter_unit.sv =====
// Shared iterative unit: bit-serial square root and restoring divide.
module kas_iter_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  kas_pkg::unit_req_t        req,
  input  logic [kas_pkg::SqW-1:0]   operand,
  input  logic [kas_pkg::DvsW-1:0]  divisor,
  output kas_pkg::unit_sts_t        sts,
  output logic [kas_pkg::SqW-1:0]   result
);
  import kas_pkg::*;

  logic            busy, done, mode;
  logic [CntW-1:0] cnt;
  logic [SqW-1:0]  acc, quo;
  logic [RemW-1:0] rem, rem_sh, trial;
  logic [DvsW-1:0] dvs;
  logic            ge;

  always_comb begin
    if (mode) begin
      rem_sh = {rem[RemW-3:0], acc[SqW-1 -: 2]};
      trial  = {2'b00, quo[SqW/2-1:0], 2'b01};
    end else begin
      rem_sh = {rem[RemW-2:0], acc[SqW-1]};
      trial  = RemW'(dvs);
    end
    ge = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.sqrt_mode ? CntW'(SqW/2-1) : CntW'(SqW-1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc  <= operand;
      dvs  <= divisor;
      rem  <= '0;
      quo  <= '0;
      mode <= req.sqrt_mode;
    end else if (busy) begin
      acc <= mode ? {acc[SqW-3:0], 2'b00} : {acc[SqW-2:0], 1'b0};
      rem <= ge ? rem_sh - trial : rem_sh;
      quo <= {quo[SqW-2:0], ge};
    end
  end

  assign sts    = '{busy: busy, done: done};
  assign result = quo;

endmodule

// ===== hdl/ball_kick_approach_steering_top.sv =====
// Top level: steering sequencer, state, configuration and command register.
//
//  channel | direction | handshake          | payload
//  tick    | in        | tick_valid/stall   | kas_pkg::tick_t
//  cmd     | out       | cmd_valid/stall    | kas_pkg::cmd_t
//  cfg     | in        | cfg_we             | cfg_index, cfg_data
//
// One request at a time. The approach case runs two square roots of 18 steps and
// four divides of 36 steps, all on the one shared unit. Reset is synchronous and
// clears the kick state and loads the register defaults. The command register holds
// a result under stall; the next request is taken while it waits.
module ball_kick_approach_steering_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           tick_valid,
  output logic           tick_stall,
  input  kas_pkg::tick_t tick,
  output logic           cmd_valid,
  input  logic           cmd_stall,
  output kas_pkg::cmd_t  cmd,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [15:0]    cfg_data
);
  import kas_pkg::*;

  state_t state, state_next;
  phase_t ph;
  tick_t  tk;

  logic signed [CoordW-1:0] goal_x, goal_y;
  logic [11:0]              kick_range;
  logic [15:0]              hold_ms;
  logic [7:0]               kick_strength;
  logic [SpdW-1:0]          far_speed;

  logic        kicked;
  logic [31:0] last_kick;

  logic signed [DiffW-1:0]  dx, dy;
  logic [SpdW-1:0]          speed;
  logic [SqW-1:0]           prod, sumsq;
  logic [23:0]              kdsq;
  logic [DiffW-1:0]         r;
  logic signed [CoordW-1:0] vx, vy;
  logic                     kick_r;

  logic [DiffW-1:0] mul_a, mul_b, adx, ady;
  logic [SqW-1:0]   mul_p;

  unit_req_t        u_req;
  unit_sts_t        u_sts;
  logic [SqW-1:0]   u_op, u_res;
  logic [DvsW-1:0]  u_dvs;

  logic signed [DiffW-1:0] rx_e, ry_e, bx_e, by_e, gx_e, gy_e, sx, sd, sup_dx, sup_dy;
  logic both_valid, cool_over, is_kick, out_free, accept;

  assign accept     = tick_valid && !tick_stall;
  assign tick_stall = state != S_IDLE;
  assign out_free   = !cmd_valid || !cmd_stall;

  assign rx_e = DiffW'(tk.robot_x);
  assign ry_e = DiffW'(tk.robot_y);
  assign bx_e = DiffW'(tk.ball_x);
  assign by_e = DiffW'(tk.ball_y);
  assign gx_e = DiffW'(goal_x);
  assign gy_e = DiffW'(goal_y);

  always_comb begin
    sx = bx_e - SupportBack;
    if (sx < SupportMinX) sx = SupportMinX;
    sd = sx - rx_e;
    sup_dx = {sd[DiffW-2:0], 1'b0};
    sup_dy = by_e - {ry_e[DiffW-2:0], 1'b0};
  end

  assign both_valid = tk.robot_valid && tk.ball_valid;
  assign cool_over  = (tk.now_ms - last_kick) > {16'd0, hold_ms};
  assign is_kick    = sumsq < SqW'(kdsq);

  assign adx = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
  assign ady = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);

  // shared multiplier
  always_comb begin
    unique case (state)
      S_KSQ:   begin mul_a = DiffW'(kick_range); mul_b = DiffW'(kick_range); end
      S_SQX:   begin mul_a = adx; mul_b = adx; end
      S_SQY:   begin mul_a = ady; mul_b = ady; end
      S_MULX:  begin mul_a = adx; mul_b = DiffW'(speed); end
      S_MULY:  begin mul_a = ady; mul_b = DiffW'(speed); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign u_req.start     = state == S_ROOT || state == S_DIVX || state == S_DIVY;
  assign u_req.sqrt_mode = state == S_ROOT;
  assign u_op  = (state == S_ROOT) ? sumsq : {prod[SqW-2:0], 1'b0} + SqW'(r);
  assign u_dvs = {1'b0, r, 1'b0};

  kas_iter_unit u_unit (
    .clk     (clk),
    .rst     (rst),
    .req     (u_req),
    .operand (u_op),
    .divisor (u_dvs),
    .sts     (u_sts),
    .result  (u_res)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_DECIDE;
      S_DECIDE: begin
        if (!both_valid) state_next = S_OUT;
        else if (kicked && !cool_over) state_next = S_SQX;
        else state_next = S_KSQ;
      end
      S_KSQ:    state_next = S_SQX;
      S_SQX:    state_next = S_SQY;
      S_SQY:    state_next = S_SQA;
      S_SQA:    state_next = S_CHECK;
      S_CHECK: begin
        unique case (ph)
          PH_SUPPORT:  state_next = (sumsq > SupportNearSq) ? S_ROOT : S_OUT;
          PH_APPROACH: state_next = (sumsq > ApproachNearSq) ? S_ROOT : S_OUT;
          PH_CLASS: begin
            if (is_kick) state_next = S_SQX;
            else if (sumsq < ChaseSq) state_next = S_ROOT;
            else state_next = S_SQX;
          end
          default:     state_next = S_ROOT;
        endcase
      end
      S_ROOT:   state_next = S_ROOTW;
      S_ROOTW:  if (u_sts.done) state_next = (u_res == '0) ? S_OUT : S_MULX;
      S_MULX:   state_next = S_DIVX;
      S_DIVX:   state_next = S_DIVXW;
      S_DIVXW:  if (u_sts.done) state_next = S_MULY;
      S_MULY:   state_next = S_DIVY;
      S_DIVY:   state_next = S_DIVYW;
      S_DIVYW:  if (u_sts.done) state_next = (ph == PH_GOAL) ? S_NEXT : S_OUT;
      S_NEXT:   state_next = S_SQX;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (accept) tk <= tick;
      S_DECIDE: begin
        vx     <= '0;
        vy     <= '0;
        kick_r <= 1'b0;
        if (kicked && !cool_over) begin
          ph    <= PH_SUPPORT;
          dx    <= sup_dx;
          dy    <= sup_dy;
          speed <= SpdSupport;
        end else begin
          ph <= PH_CLASS;
          dx <= bx_e - rx_e;
          dy <= by_e - ry_e;
        end
      end
      S_KSQ: kdsq <= mul_p[23:0];
      S_SQX: prod <= mul_p;
      S_SQY: begin
        sumsq <= prod;
        prod  <= mul_p;
      end
      S_SQA: sumsq <= sumsq + prod;
      S_CHECK: begin
        if (ph == PH_CLASS) begin
          speed <= SpdFast;
          if (is_kick) begin
            kick_r <= 1'b1;
            ph     <= PH_KICK;
            dx     <= gx_e - rx_e;
            dy     <= gy_e - ry_e;
          end else if (sumsq < ChaseSq) begin
            ph <= PH_CHASE;
          end else begin
            ph    <= PH_GOAL;
            speed <= ApproachBack;
            dx    <= gx_e - bx_e;
            dy    <= gy_e - by_e;
          end
        end
      end
      S_ROOTW: if (u_sts.done) r <= u_res[DiffW-1:0];
      S_MULX:  prod <= mul_p;
      S_DIVXW: if (u_sts.done) vx <= sat_q(u_res, dx[DiffW-1]);
      S_MULY:  prod <= mul_p;
      S_DIVYW: if (u_sts.done) vy <= sat_q(u_res, dy[DiffW-1]);
      S_NEXT: begin
        dx    <= bx_e - DiffW'(vx) - rx_e;
        dy    <= by_e - DiffW'(vy) - ry_e;
        vx    <= '0;
        vy    <= '0;
        ph    <= PH_APPROACH;
        speed <= far_speed;
      end
      default: ;
    endcase
  end

  // kick state
  always_ff @(posedge clk) begin
    if (rst) begin
      kicked    <= 1'b0;
      last_kick <= '0;
    end else if (state == S_DECIDE && both_valid && kicked && cool_over) begin
      kicked <= 1'b0;
    end else if (state == S_CHECK && ph == PH_CLASS && is_kick) begin
      kicked    <= 1'b1;
      last_kick <= tk.now_ms;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x        <= 16'sd4500;
      goal_y        <= '0;
      kick_range    <= 12'd120;
      hold_ms       <= 16'd500;
      kick_strength <= 8'd200;
      far_speed     <= 15'd4096;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GOAL_X:        goal_x <= $signed(cfg_data);
        CFG_GOAL_Y:        goal_y <= $signed(cfg_data);
        CFG_KICK_RANGE:    kick_range <= cfg_data[11:0];
        CFG_HOLD_MS:       hold_ms <= cfg_data;
        CFG_KICK_STRENGTH: kick_strength <= cfg_data[7:0];
        CFG_FAR_SPEED:     far_speed <= cfg_data[SpdW-1:0];
        default: ;
      endcase
    end
  end

  // command register
  always_ff @(posedge clk) begin
    if (rst) cmd_valid <= 1'b0;
    else if (state == S_OUT && out_free) cmd_valid <= 1'b1;
    else if (!cmd_stall) cmd_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      cmd.cmd_bot_id     <= tk.bot_id;
      cmd.vel_x          <= vx;
      cmd.vel_y          <= vy;
      cmd.kick           <= kick_r;
      cmd.kick_power_out <= kick_r ? kick_strength : 8'd0;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    u_req.start |-> !u_sts.busy) else $error("unit started while busy");
  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    u_sts.done |-> !u_sts.busy) else $error("unit done while busy");
  a_no_kick_power: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd.kick |-> cmd.kick_power_out == 8'd0) else $error("power without kick");
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(cmd_valid) |-> $past(state) == S_OUT) else $error("command not from sequencer");

endmodule

// ===== test/testbench.sv =====
// Testbench for the ball kick approach steering block with a behavioural predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kas_pkg::*;

  logic       clk = 0;
  logic       rst = 1;
  logic       tick_valid = 0;
  logic       tick_stall;
  tick_t      tick = '0;
  logic       cmd_valid;
  logic       cmd_stall = 0;
  cmd_t       cmd;
  logic       cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  ball_kick_approach_steering_top dut (
    .clk(clk), .rst(rst),
    .tick_valid(tick_valid), .tick_stall(tick_stall), .tick(tick),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of registers and kick state
  longint goal_x_m, goal_y_m, kick_dist_m, cooldown_m, strength_m, appr_speed_m;
  bit          kicked_m;
  logic [31:0] kick_time_m;

  cmd_t        cmd_expected[$];
  int          errors = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  bit          hold_go = 0;
  int          hold_cnt = 0;
  logic [31:0] clock_ms = 0;

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // comp*speed/r rounded half away from zero, saturated to 16 bits
  function automatic longint unit_scale(longint comp, longint unsigned r, longint unsigned spd);
    longint unsigned mag, q;
    if (r == 0) return 0;
    mag = (comp < 0) ? -comp : comp;
    q = (2 * mag * spd + r) / (2 * r);
    if (comp < 0) return (q > 32768) ? -32768 : -longint'(q);
    return (q > 32767) ? 32767 : longint'(q);
  endfunction

  function automatic cmd_t steer_cmd(tick_t t);
    cmd_t c;
    longint rx, ry, bx, by, sx, dx, dy, s, gdx, gdy, ax, ay, vx, vy;
    longint unsigned r, g;
    logic [31:0] el;
    bit done, kick;
    rx = t.robot_x; ry = t.robot_y; bx = t.ball_x; by = t.ball_y;
    vx = 0; vy = 0; kick = 0;
    if (t.robot_valid && t.ball_valid) begin
      done = 0;
      if (kicked_m) begin
        el = t.now_ms - kick_time_m;
        if (el > cooldown_m) begin
          kicked_m = 0;
        end else begin
          sx = bx - 800;
          if (sx < -3500) sx = -3500;
          dx = 2 * (sx - rx);
          dy = by - 2 * ry;
          if (dx * dx + dy * dy > 25600) begin
            r = int_root(dx * dx + dy * dy);
            vx = unit_scale(dx, r, SpdSupport);
            vy = unit_scale(dy, r, SpdSupport);
          end
          done = 1;
        end
      end
      if (!done) begin
        dx = bx - rx;
        dy = by - ry;
        s = dx * dx + dy * dy;
        if (s < kick_dist_m * kick_dist_m) begin
          r = int_root((goal_x_m - rx) ** 2 + (goal_y_m - ry) ** 2);
          vx = unit_scale(goal_x_m - rx, r, SpdFast);
          vy = unit_scale(goal_y_m - ry, r, SpdFast);
          kick = 1;
          kicked_m = 1;
          kick_time_m = t.now_ms;
        end else if (s < 360000) begin
          r = int_root(s);
          vx = unit_scale(dx, r, SpdFast);
          vy = unit_scale(dy, r, SpdFast);
        end else begin
          gdx = goal_x_m - bx;
          gdy = goal_y_m - by;
          g = int_root(gdx * gdx + gdy * gdy);
          if (g != 0) begin
            ax = bx - unit_scale(gdx, g, ApproachBack);
            ay = by - unit_scale(gdy, g, ApproachBack);
            dx = ax - rx;
            dy = ay - ry;
            if (dx * dx + dy * dy > 900) begin
              r = int_root(dx * dx + dy * dy);
              vx = unit_scale(dx, r, appr_speed_m);
              vy = unit_scale(dy, r, appr_speed_m);
            end
          end
        end
      end
    end
    c.cmd_bot_id     = t.bot_id;
    c.vel_x          = vx[15:0];
    c.vel_y          = vy[15:0];
    c.kick           = kick;
    c.kick_power_out = kick ? strength_m[7:0] : 8'd0;
    return c;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) begin
      cmd_stall <= 1;
      hold_cnt++;
      if (hold_cnt == 600) begin
        hold_go = 0;
        hold_cnt = 0;
      end
    end else begin
      cmd_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    cmd_t e;
    if (!rst && cmd_valid && !cmd_stall) begin
      if (cmd_expected.size() == 0) begin
        $error("unexpected command %h", cmd);
        errors++;
      end else begin
        e = cmd_expected.pop_front();
        if (cmd.cmd_bot_id !== e.cmd_bot_id) begin
          $error("cmd_bot_id expected %0d got %0d", e.cmd_bot_id, cmd.cmd_bot_id);
          errors++;
        end
        if (cmd.vel_x !== e.vel_x) begin
          $error("vel_x expected %0d got %0d", e.vel_x, cmd.vel_x);
          errors++;
        end
        if (cmd.vel_y !== e.vel_y) begin
          $error("vel_y expected %0d got %0d", e.vel_y, cmd.vel_y);
          errors++;
        end
        if (cmd.kick !== e.kick) begin
          $error("kick expected %0d got %0d", e.kick, cmd.kick);
          errors++;
        end
        if (cmd.kick_power_out !== e.kick_power_out) begin
          $error("kick_power_out expected %0d got %0d", e.kick_power_out, cmd.kick_power_out);
          errors++;
        end
      end
    end
  end

  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < send_idle) begin
      tick_valid <= 0;
      @(posedge clk);
    end
    tick_valid <= 1;
    tick <= t;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    cmd_expected.push_back(steer_cmd(t));
  endtask

  task automatic drain;
    tick_valid <= 0;
    @(posedge clk);
    while (cmd_expected.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v[15:0];
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_GOAL_X:        goal_x_m = $signed(v[15:0]);
      CFG_GOAL_Y:        goal_y_m = $signed(v[15:0]);
      CFG_KICK_RANGE:    kick_dist_m = v[11:0];
      CFG_HOLD_MS:       cooldown_m = v[15:0];
      CFG_KICK_STRENGTH: strength_m = v[7:0];
      CFG_FAR_SPEED:     appr_speed_m = v[14:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input int gx, gy, kd, cd, ks, sp);
    drain();
    write_reg(CFG_GOAL_X, gx);
    write_reg(CFG_GOAL_Y, gy);
    write_reg(CFG_KICK_RANGE, kd);
    write_reg(CFG_HOLD_MS, cd);
    write_reg(CFG_KICK_STRENGTH, ks);
    write_reg(CFG_FAR_SPEED, sp);
  endtask

  function automatic tick_t make_tick(bit rv, bit bv, int rx, ry, bx, by, logic [31:0] ms);
    tick_t t;
    t.bot_id = 4'($urandom_range(15));
    t.robot_valid = rv;
    t.ball_valid = bv;
    t.robot_x = rx[15:0];
    t.robot_y = ry[15:0];
    t.ball_x = bx[15:0];
    t.ball_y = by[15:0];
    t.now_ms = ms;
    return t;
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    logic [127:0] raw;
    int mode, bx, by, sp;
    mode = $urandom_range(99);
    if ($urandom_range(19) == 0) clock_ms += $urandom;
    else clock_ms += $urandom_range(60);
    if (mode < 15) begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      t = raw[$bits(tick_t)-1:0];
      if (mode < 8) {t.robot_valid, t.ball_valid} = 2'($urandom_range(2));
      return t;
    end
    bx = int'($urandom_range(12000)) - 6000;
    by = int'($urandom_range(8000)) - 4000;
    case ($urandom_range(2))
      0: sp = 150;
      1: sp = 700;
      default: sp = 6000;
    endcase
    return make_tick(1, 1, bx + int'($urandom_range(2 * sp)) - sp,
                     by + int'($urandom_range(2 * sp)) - sp, bx, by, clock_ms);
  endfunction

  task automatic test_directed;
    send_tick(make_tick(0, 1, 0, 0, 10, 10, 32'd0));
    send_tick(make_tick(1, 0, 0, 0, 10, 10, 32'd0));
    send_tick(make_tick(0, 0, -32768, 32767, 32767, -32768, 32'hFFFF_FFFF));
    send_tick(make_tick(1, 1, -32768, -32768, 32767, 32767, 32'd100));
    // ball sitting on the goal
    send_tick(make_tick(1, 1, 0, 0, 4500, 0, 32'd110));
    // robot within chase range of the ball
    send_tick(make_tick(1, 1, -290, 10, 0, 0, 32'd120));
    send_tick(make_tick(1, 1, 0, 0, 400, -300, 32'd130));
    // kick from the goal itself: no direction
    send_tick(make_tick(1, 1, 4500, 0, 4550, 0, 32'd1000));
    send_tick(make_tick(1, 1, 5000, 5000, 0, 0, 32'd1200));
    send_tick(make_tick(1, 1, -800, 20, 0, 0, 32'd1300));
    send_tick(make_tick(1, 1, 32767, -32768, -32768, 32767, 32'd1500));
    send_tick(make_tick(1, 1, 0, 0, 1000, 0, 32'd1501));
    // cooldown across the timestamp wrap
    send_tick(make_tick(1, 1, 100, 100, 100, 100, 32'hFFFF_FF00));
    send_tick(make_tick(1, 1, 0, 0, 300, 300, 32'h0000_00F0));
    send_tick(make_tick(1, 1, 0, 0, 300, 300, 32'h0000_0200));
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      case ((i / 65) % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 62; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 62; end
        default: begin send_idle = 30; recv_stall = 30; end
      endcase
      send_tick(random_tick());
    end
    send_idle = 0;
    recv_stall = 0;
  endtask

  task automatic test_backpressure;
    drain();
    hold_go = 1;
    for (int i = 0; i < 16; i++) send_tick(random_tick());
  endtask

  task automatic test_settings;
    load_setting(-32768, 32767, 4095, 0, 255, 32767);
    test_random(260);
    load_setting(32767, -32768, 0, 65535, 0, 0);
    test_random(260);
    load_setting(-4500, 1500, 300, 1000, 1, 20000);
    test_random(260);
    load_setting(0, 0, 600, 200, 128, 8192);
    test_random(260);
    load_setting(1000, -2000, 50, 65535, 77, 1);
    test_random(260);
    load_setting(4500, 0, 120, 500, 200, 4096);
    test_random(260);
  endtask

  initial begin
    goal_x_m = 4500; goal_y_m = 0; kick_dist_m = 120;
    cooldown_m = 500; strength_m = 200; appr_speed_m = 4096;
    kicked_m = 0;
    kick_time_m = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(260);
    test_backpressure();
    test_settings();
    drain();
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

  initial begin
    #40ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
